### hw/rtl/swdb_pkg.sv
package swdb_pkg;

    localparam int TICK_COUNT_BITS_DEFAULT = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int MIN_W = 7;
    localparam int SEC_W = 6;
    localparam int MS_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd35;
    localparam logic [CFG_W-1:0] DISPLAY_RESET  = 16'd50;
    localparam logic [CFG_W-1:0] BLINK_RESET    = 16'd500;

    localparam logic [MIN_W-1:0] MIN_LIMIT = 7'd100;
    localparam logic [MIN_W-1:0] MIN_SHOW  = 7'd99;
    localparam logic [SEC_W-1:0] SEC_LAST  = 6'd59;
    localparam logic [MS_W-1:0]  MS_LAST   = 10'd999;

    typedef struct packed {
        logic [MIN_W-1:0] min;
        logic [SEC_W-1:0] sec;
        logic [MS_W-1:0]  ms;
    } time_t;

    typedef struct packed {
        logic step;
        logic advance;
        logic clear;
    } time_ctl_t;

endpackage

### hw/rtl/swdb_time.sv
module swdb_time (
    input  logic               clk,
    input  logic               rst_n,
    input  swdb_pkg::time_ctl_t ctl,
    output swdb_pkg::time_t    shown
);
    import swdb_pkg::*;

    logic [MIN_W-1:0] min_reg, min_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [MS_W-1:0]  ms_reg, ms_next;

    always_comb
    begin
        min_next = min_reg;
        sec_next = sec_reg;
        ms_next  = ms_reg;
        if (ctl.advance && (min_reg < MIN_LIMIT))
        begin
            if (ms_reg == MS_LAST)
            begin
                ms_next = '0;
                if (sec_reg == SEC_LAST)
                begin
                    sec_next = '0;
                    min_next = min_reg + MIN_W'(1);
                end
                else
                begin
                    sec_next = sec_reg + SEC_W'(1);
                end
            end
            else
            begin
                ms_next = ms_reg + MS_W'(1);
            end
        end
        if (ctl.clear)
        begin
            min_next = '0;
            sec_next = '0;
            ms_next  = '0;
        end
    end

    always_comb
    begin
        if (min_next >= MIN_LIMIT)
        begin
            shown.min = MIN_SHOW;
            shown.sec = SEC_LAST;
            shown.ms  = MS_LAST;
        end
        else
        begin
            shown.min = min_next;
            shown.sec = sec_next;
            shown.ms  = ms_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            sec_reg <= '0;
            ms_reg  <= '0;
        end
        else if (ctl.step)
        begin
            min_reg <= min_next;
            sec_reg <= sec_next;
            ms_reg  <= ms_next;
        end
    end

    a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg <= MIN_LIMIT) else $error("minutes beyond limit");
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg <= SEC_LAST) else $error("seconds out of range");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && ctl.clear |=> min_reg == '0 && sec_reg == '0 && ms_reg == '0)
        else $error("clear did not zero time");

endmodule

### hw/rtl/swdb_debounce.sv
module swdb_debounce #(
    parameter int TICK_COUNT_BITS = swdb_pkg::TICK_COUNT_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       key,
    input  logic [swdb_pkg::CFG_W-1:0] debounce_ticks,
    output logic                       fired
);
    import swdb_pkg::*;

    localparam int CMP_W = (TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W;

    logic                       key_last_reg, key_last_next;
    logic                       key_stable_reg, key_stable_next;
    logic [TICK_COUNT_BITS-1:0] key_age_reg, key_age_next;
    logic                       settled;

    always_comb
    begin
        key_last_next = key;
        if (key != key_last_reg)
            key_age_next = '0;
        else if (&key_age_reg)
            key_age_next = key_age_reg;
        else
            key_age_next = key_age_reg + TICK_COUNT_BITS'(1);
        settled = CMP_W'(key_age_next) >= CMP_W'(debounce_ticks);
        key_stable_next = key_stable_reg;
        if (settled && (key != key_stable_reg))
            key_stable_next = key;
        fired = settled && key && !key_stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_last_reg   <= 1'b0;
            key_stable_reg <= 1'b0;
            key_age_reg    <= '0;
        end
        else if (step)
        begin
            key_last_reg   <= key_last_next;
            key_stable_reg <= key_stable_next;
            key_age_reg    <= key_age_next;
        end
    end

endmodule

### hw/rtl/swdb_divider.sv
module swdb_divider #(
    parameter int TICK_COUNT_BITS = swdb_pkg::TICK_COUNT_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [swdb_pkg::CFG_W-1:0] period,
    output logic                       hit
);
    import swdb_pkg::*;

    localparam int CMP_W = (TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W;

    logic [TICK_COUNT_BITS-1:0] count_reg, count_inc;

    always_comb
    begin
        if (&count_reg)
            count_inc = count_reg;
        else
            count_inc = count_reg + TICK_COUNT_BITS'(1);
        hit = CMP_W'(count_inc) >= CMP_W'(period);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (step)
            count_reg <= hit ? '0 : count_inc;
    end

endmodule

### hw/rtl/stopwatch_with_debounced_reset.sv
// Stopwatch with debounced reset key.
// Input channel (in_valid/in_ready): one beat per millisecond tick carrying
// run_level and key_pressed. Output channel (out_valid/out_ready): one beat
// per input beat with the elapsed time, latched run state, LED level and
// the display/reset strobes after that tick.
// A result is registered and presented the cycle after its input beat is taken.
// Throughput: one beat per cycle while out_ready keeps the output draining; all tick
// logic is combinational between the state registers and the output register.
// A stalled output holds its beat; a new input beat is taken whenever the
// output register is empty or being drained in the same cycle.
// Config writes (cfg_wr_en, cfg_index, cfg_wdata) are registered; index 3
// is ignored. Write only while no beats are in flight.
// Reset: time 00:00.000, paused, key taken as released, dividers and LED
// cleared, registers at 35 / 50 / 500 ticks. Time saturates at 99:59.999.
module stopwatch_with_debounced_reset #(
    parameter int TICK_COUNT_BITS = swdb_pkg::TICK_COUNT_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [swdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swdb_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           run_level,
    input  logic                           key_pressed,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [swdb_pkg::MIN_W-1:0]     minutes,
    output logic [swdb_pkg::SEC_W-1:0]     seconds,
    output logic [swdb_pkg::MS_W-1:0]      millis,
    output logic                           running,
    output logic                           led_level,
    output logic                           display_due,
    output logic                           reset_fired
);
    import swdb_pkg::*;

    logic [CFG_W-1:0] debounce_ticks_reg;
    logic [CFG_W-1:0] display_period_reg;
    logic [CFG_W-1:0] blink_period_reg;

    logic      step;
    logic      run_latched_reg;
    logic      led_state_reg, led_state_next;
    logic      fired;
    logic      strobe;
    logic      toggle;
    time_ctl_t tctl;
    time_t     shown;

    logic             out_valid_reg;
    time_t            out_time_reg;
    logic             out_running_reg;
    logic             out_led_reg;
    logic             out_due_reg;
    logic             out_fired_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            display_period_reg <= DISPLAY_RESET;
            blink_period_reg   <= BLINK_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_ticks_reg <= cfg_wdata;
                REG_DISPLAY:  display_period_reg <= cfg_wdata;
                REG_BLINK:    blink_period_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    swdb_debounce #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .key            (key_pressed),
        .debounce_ticks (debounce_ticks_reg),
        .fired          (fired)
    );

    assign tctl.step    = step;
    assign tctl.advance = run_latched_reg;
    assign tctl.clear   = fired;

    swdb_time u_time (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tctl),
        .shown (shown)
    );

    swdb_divider #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_display_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .period (display_period_reg),
        .hit    (strobe)
    );

    swdb_divider #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_blink_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .period (blink_period_reg),
        .hit    (toggle)
    );

    assign led_state_next = led_state_reg ^ toggle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_latched_reg <= 1'b0;
            led_state_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                run_latched_reg <= run_level;
                led_state_reg   <= led_state_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_time_reg    <= shown;
            out_running_reg <= run_level;
            out_led_reg     <= led_state_next;
            out_due_reg     <= strobe || fired;
            out_fired_reg   <= fired;
        end
    end

    assign out_valid   = out_valid_reg;
    assign minutes     = out_time_reg.min;
    assign seconds     = out_time_reg.sec;
    assign millis      = out_time_reg.ms;
    assign running     = out_running_reg;
    assign led_level   = out_led_reg;
    assign display_due = out_due_reg;
    assign reset_fired = out_fired_reg;

    a_fired_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_fired |-> display_due)
        else $error("reset beat without display strobe");
    a_fired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_fired |-> minutes == '0 && seconds == '0 && millis == '0)
        else $error("reset beat shows nonzero time");
    a_run_capture: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid && running == $past(run_level))
        else $error("running does not follow taken run level");

endmodule
